### rtl/core/wsd_pkg.sv
// Shared types and constants for the websocket frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    localparam int unsigned LEN_W = 24;

    localparam logic [3:0]       OPC_REJECT        = 4'h8;
    localparam logic [6:0]       LEN7_EXT16        = 7'd126;
    localparam logic [6:0]       LEN7_EXT64        = 7'd127;
    localparam logic [2:0]       EXT16_BYTES_LEFT  = 3'd1;
    localparam logic [2:0]       EXT64_BYTES_LEFT  = 3'd7;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 24'd102040;

    typedef enum logic [2:0] {
        PH_HDR0       = 3'd0,
        PH_HDR1       = 3'd1,
        PH_EXTLEN     = 3'd2,
        PH_MASK       = 3'd3,
        PH_PAYLOAD    = 3'd4,
        PH_DEAD       = 3'd5,
        PH_HDR1_NOFIN = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    // One queued result: raw byte and key byte are combined in the back end.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic [3:0] opcode;
        kind_t      kind;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage : wsd_pkg

`default_nettype wire

### rtl/core/wsd_front.sv
// Front end: header, length and key parser; emits one command per result.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [7:0]                rx_byte,
    input  wire logic [wsd_pkg::LEN_W-1:0] max_payload,
    output wsd_pkg::cmd_t                  wr_cmd,
    output logic                           wr_en
);
    import wsd_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             big_reg, big_next;
    logic [7:0]       key_reg [4];
    logic [7:0]       key_next [4];
    logic [1:0]       pos_reg, pos_next;

    logic [6:0]       len7;
    logic             hdr_bad;
    logic             ext_start;
    logic [LEN_W-1:0] ext_len;
    logic             ext_big;
    logic             len7_over;
    logic             ext_over;

    assign len7      = rx_byte[6:0];
    assign hdr_bad   = (phase_reg == PH_HDR1_NOFIN) || !rx_byte[7];
    assign ext_start = len7 inside {LEN7_EXT16, LEN7_EXT64};
    assign ext_len   = {len_reg[LEN_W-9:0], rx_byte};
    // anything shifted above the low 24 bits makes the length too long
    assign ext_big   = big_reg || (len_reg[LEN_W-1:LEN_W-8] != 8'd0);
    assign len7_over = {{(LEN_W-7){1'b0}}, len7} > max_payload;
    assign ext_over  = ext_big || (ext_len > max_payload);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HDR0:
                    phase_next = rx_byte[7] ? PH_HDR1 : PH_HDR1_NOFIN;
                PH_HDR1, PH_HDR1_NOFIN:
                begin
                    if (hdr_bad)
                        phase_next = PH_DEAD;
                    else if (ext_start)
                        phase_next = PH_EXTLEN;
                    else
                        phase_next = len7_over ? PH_DEAD : PH_MASK;
                end
                PH_EXTLEN:
                    if (cnt_reg == 3'd0)
                        phase_next = ext_over ? PH_DEAD : PH_MASK;
                PH_MASK:
                    if (pos_reg == 2'd3)
                        phase_next = (len_reg == '0) ? PH_HDR0 : PH_PAYLOAD;
                PH_PAYLOAD:
                    if (len_reg == LEN_W'(1))
                        phase_next = PH_HDR0;
                default:
                    phase_next = PH_DEAD;
            endcase
        end
    end

    // datapath and result commands
    always_comb
    begin
        opcode_next = opcode_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        big_next    = big_reg;
        pos_next    = pos_reg;
        for (int i = 0; i < 4; i++)
            key_next[i] = key_reg[i];
        wr_en         = 1'b0;
        wr_cmd.data   = 8'd0;
        wr_cmd.key    = 8'd0;
        wr_cmd.opcode = OPC_REJECT;
        wr_cmd.kind   = KIND_REJECT;
        wr_cmd.last   = 1'b1;
        if (accept)
        begin
            case (phase_reg)
                PH_HDR0:
                    opcode_next = rx_byte[3:0];
                PH_HDR1, PH_HDR1_NOFIN:
                begin
                    if (hdr_bad)
                    begin
                        opcode_next = OPC_REJECT;
                        wr_en       = 1'b1;
                    end
                    else
                    begin
                        len_next = '0;
                        big_next = 1'b0;
                        if (len7 == LEN7_EXT16)
                            cnt_next = EXT16_BYTES_LEFT;
                        else if (len7 == LEN7_EXT64)
                            cnt_next = EXT64_BYTES_LEFT;
                        else
                        begin
                            len_next = {{(LEN_W-7){1'b0}}, len7};
                            if (len7_over)
                            begin
                                opcode_next = OPC_REJECT;
                                wr_en       = 1'b1;
                            end
                            else
                                pos_next = 2'd0;
                        end
                    end
                end
                PH_EXTLEN:
                begin
                    len_next = ext_len;
                    big_next = ext_big;
                    if (cnt_reg == 3'd0)
                    begin
                        if (ext_over)
                        begin
                            opcode_next = OPC_REJECT;
                            wr_en       = 1'b1;
                        end
                        else
                            pos_next = 2'd0;
                    end
                    else
                        cnt_next = cnt_reg - 3'd1;
                end
                PH_MASK:
                begin
                    key_next[pos_reg] = rx_byte;
                    pos_next          = pos_reg + 2'd1;
                    if (pos_reg == 2'd3 && len_reg == '0)
                    begin
                        wr_en         = 1'b1;
                        wr_cmd.opcode = opcode_reg;
                        wr_cmd.kind   = KIND_EMPTY;
                    end
                end
                PH_PAYLOAD:
                begin
                    wr_en         = 1'b1;
                    wr_cmd.data   = rx_byte;
                    wr_cmd.key    = key_reg[pos_reg];
                    wr_cmd.opcode = opcode_reg;
                    wr_cmd.kind   = KIND_PAYLOAD;
                    wr_cmd.last   = (len_reg == LEN_W'(1));
                    len_next      = len_reg - LEN_W'(1);
                    pos_next      = wr_cmd.last ? 2'd0 : pos_reg + 2'd1;
                end
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= 4'd0;
            cnt_reg    <= 3'd0;
            len_reg    <= '0;
            big_reg    <= 1'b0;
            pos_reg    <= 2'd0;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            cnt_reg    <= cnt_next;
            len_reg    <= len_next;
            big_reg    <= big_next;
            pos_reg    <= pos_next;
            for (int i = 0; i < 4; i++)
                key_reg[i] <= key_next[i];
        end
    end

endmodule : wsd_front

`default_nettype wire

### rtl/core/wsd_fifo.sv
// Short command queue between the parser and the output stage.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wsd_pkg::cmd_t      wr_cmd,
    input  wire logic          rd_en,
    output wsd_pkg::cmd_t      rd_cmd,
    output wsd_pkg::fifo_stat_t stat
);
    import wsd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_cmd     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_cmd;
    end

endmodule : wsd_fifo

`default_nettype wire

### rtl/core/wsd_back.sv
// Back end: unmasks queued commands into the output register.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wsd_pkg::cmd_t       q_cmd,
    output logic                q_rd,
    input  wire logic           pop,
    output logic                empty,
    output logic [7:0]          out_byte,
    output logic [3:0]          frame_opcode,
    output logic [1:0]          kind,
    output logic                last
);
    import wsd_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [3:0] opc_reg, opc_next;
    kind_t      kind_reg, kind_next;
    logic       last_reg, last_next;
    logic       load;

    // refill when the output slot is free or its beat leaves this cycle
    assign load = !valid_reg || pop;
    assign q_rd = load && !q_empty;

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        opc_next   = opc_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = !q_empty;
            byte_next  = q_cmd.data ^ q_cmd.key;
            opc_next   = q_cmd.opcode;
            kind_next  = q_cmd.kind;
            last_next  = q_cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        opc_reg  <= opc_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign empty        = !valid_reg;
    assign out_byte     = byte_reg;
    assign frame_opcode = opc_reg;
    assign kind         = kind_reg;
    assign last         = last_reg;

endmodule : wsd_back

`default_nettype wire

### rtl/core/websocket_frame_deframer_top.sv
// Websocket receive deframer: one stream byte per push, unmasked payload
// beats out. Takes one byte per cycle while full is low; each byte is parsed
// in the cycle it is accepted and any result lands in a DEPTH-entry queue
// ahead of a one-entry output register, so full only rises when DEPTH+1
// results are waiting. A result is written into the queue at the edge that
// accepts its byte and is then loaded into the output register. After a
// rejected frame every later byte is taken and dropped until reset.
// max_payload is written through cfg_we/cfg_wdata.
// Depends on wsd_pkg, wsd_front, wsd_fifo, wsd_back.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_top #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [7:0]                rx_byte,
    input  wire logic                      pop,
    output logic                           empty,
    output logic [7:0]                     out_byte,
    output logic [3:0]                     frame_opcode,
    output logic [1:0]                     kind,
    output logic                           last,
    input  wire logic                      cfg_we,
    input  wire logic [wsd_pkg::LEN_W-1:0] cfg_wdata
);
    import wsd_pkg::*;

    logic [LEN_W-1:0] max_payload_reg, max_payload_next;
    logic             accept;
    logic             q_wr, q_rd;
    cmd_t             q_wr_cmd, q_rd_cmd;
    fifo_stat_t       q_stat;

    assign full             = q_stat.full;
    assign accept           = push && !q_stat.full;
    assign max_payload_next = cfg_we ? cfg_wdata : max_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RESET;
        else
            max_payload_reg <= max_payload_next;
    end

    wsd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .max_payload (max_payload_reg),
        .wr_cmd      (q_wr_cmd),
        .wr_en       (q_wr)
    );

    wsd_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr),
        .wr_cmd (q_wr_cmd),
        .rd_en  (q_rd),
        .rd_cmd (q_rd_cmd),
        .stat   (q_stat)
    );

    wsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_stat.empty),
        .q_cmd        (q_rd_cmd),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .frame_opcode (frame_opcode),
        .kind         (kind),
        .last         (last)
    );

`ifndef SYNTHESIS
    // the output stage always drains the queue first
    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !empty)
        else $error("queue full while output register is empty");

    a_full_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_stat.full) |-> $past(q_wr))
        else $error("queue filled without a write");

    a_reject_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_REJECT) |->
            (last && frame_opcode == OPC_REJECT && out_byte == 8'd0))
        else $error("malformed rejection beat");

    a_empty_frame_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_EMPTY) |-> (last && out_byte == 8'd0))
        else $error("malformed empty-frame beat");
`endif

endmodule : websocket_frame_deframer_top

`default_nettype wire

### dv/testbench.sv
// Self-checking bench for websocket_frame_deframer_top: walks a directed stream
// table, then random masked frames over several max_payload settings, and ends
// on one rejected frame. Needs wsd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module testbench;
    import wsd_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int N_DIRECTED    = 25;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] opcode;
        kind_t      kind;
        logic       last;
    } beat_t;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        logic       has;
        beat_t      res;
    } stim_row_t;

    localparam beat_t NO_BEAT = '0;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             push      = 1'b0;
    logic [7:0]       rx_byte   = 8'h00;
    logic             pop       = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             full;
    logic             empty;
    logic [7:0]       out_byte;
    logic [3:0]       frame_opcode;
    logic [1:0]       kind;
    logic             last;

    // Deframer state as the bench sees it
    phase_t           pr_phase  = PH_HDR0;
    logic [3:0]       pr_opcode = 4'h0;
    logic [2:0]       pr_extcnt = 3'd0;
    logic [63:0]      pr_left   = 64'd0;
    logic [7:0]       pr_key [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [1:0]       pr_pos    = 2'd0;
    logic [LEN_W-1:0] pr_max    = MAX_PAYLOAD_RESET;

    beat_t expected_beats [$];
    int    mismatches   = 0;
    int    beats_checked = 0;
    int    bytes_in     = 0;
    int    frames_sent  = 0;
    int    stall_cycles = 0;
    int    reject_case  = 0;
    bit    tx_burst     = 1'b0;
    bit    rx_burst     = 1'b0;
    bit    hold_request = 1'b0;

    // After reset: an empty text frame, a three-byte close frame with every
    // reserved bit set, and a ping whose length comes as 16-bit extended.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{8'h81, 1'b1, 1'b0, NO_BEAT},
        '{8'h80, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 1'b0, NO_BEAT},
        '{8'hFF, 1'b1, 1'b1, '{8'h00, 4'h1, KIND_EMPTY, 1'b1}},
        '{8'hF8, 1'b1, 1'b0, NO_BEAT},
        '{8'h83, 1'b1, 1'b0, NO_BEAT},
        '{8'hA5, 1'b0, 1'b0, NO_BEAT},
        '{8'h5A, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'h3C, 1'b0, 1'b0, NO_BEAT},
        '{8'h89, 1'b1, 1'b0, NO_BEAT},
        '{8'hFE, 1'b1, 1'b0, NO_BEAT},
        '{8'h00, 1'b1, 1'b0, NO_BEAT},
        '{8'h02, 1'b0, 1'b0, NO_BEAT},
        '{8'h12, 1'b0, 1'b0, NO_BEAT},
        '{8'h34, 1'b0, 1'b0, NO_BEAT},
        '{8'h56, 1'b0, 1'b0, NO_BEAT},
        '{8'h78, 1'b0, 1'b0, NO_BEAT},
        '{8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{8'h00, 1'b0, 1'b0, NO_BEAT}
    };

    websocket_frame_deframer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .pop          (pop),
        .empty        (empty),
        .out_byte     (out_byte),
        .frame_opcode (frame_opcode),
        .kind         (kind),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic bit reject_beat(output beat_t r);
        pr_opcode = OPC_REJECT;
        pr_phase  = PH_DEAD;
        r = '{8'h00, OPC_REJECT, KIND_REJECT, 1'b1};
        return 1'b1;
    endfunction

    function automatic bit close_length(output beat_t r);
        r = NO_BEAT;
        if (pr_left > {40'd0, pr_max})
            return reject_beat(r);
        pr_phase = PH_MASK;
        pr_pos   = 2'd0;
        return 1'b0;
    endfunction

    // Advance the deframer state by one stream byte; return 1 with the beat it emits.
    function automatic bit deframe_byte(input logic [7:0] b, output beat_t r);
        logic [6:0] len7;
        r = NO_BEAT;
        case (pr_phase)
            PH_HDR0:
            begin
                pr_opcode = b[3:0];
                pr_phase  = b[7] ? PH_HDR1 : PH_HDR1_NOFIN;
                return 1'b0;
            end
            PH_HDR1, PH_HDR1_NOFIN:
            begin
                if (pr_phase == PH_HDR1_NOFIN || !b[7])
                    return reject_beat(r);
                len7    = b[6:0];
                pr_left = 64'd0;
                if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64)
                begin
                    pr_extcnt = (len7 == LEN7_EXT16) ? EXT16_BYTES_LEFT : EXT64_BYTES_LEFT;
                    pr_phase  = PH_EXTLEN;
                    return 1'b0;
                end
                pr_left = {57'd0, len7};
                return close_length(r);
            end
            PH_EXTLEN:
            begin
                pr_left = {pr_left[55:0], b};
                if (pr_extcnt == 3'd0)
                    return close_length(r);
                pr_extcnt = pr_extcnt - 3'd1;
                return 1'b0;
            end
            PH_MASK:
            begin
                pr_key[pr_pos] = b;
                pr_pos = pr_pos + 2'd1;
                if (pr_pos != 2'd0)
                    return 1'b0;
                if (pr_left == 64'd0)
                begin
                    pr_phase = PH_HDR0;
                    r = '{8'h00, pr_opcode, KIND_EMPTY, 1'b1};
                    return 1'b1;
                end
                pr_phase = PH_PAYLOAD;
                return 1'b0;
            end
            PH_PAYLOAD:
            begin
                r.data   = b ^ pr_key[pr_pos];
                r.opcode = pr_opcode;
                r.kind   = KIND_PAYLOAD;
                pr_pos   = pr_pos + 2'd1;
                pr_left  = pr_left - 64'd1;
                r.last   = (pr_left == 64'd0);
                if (r.last)
                begin
                    pr_phase = PH_HDR0;
                    pr_pos   = 2'd0;
                end
                return 1'b1;
            end
            default:
            begin
                pr_phase = PH_DEAD;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
        mismatches++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    endtask

    // Compare every popped beat with the oldest expectation.
    always @(posedge clk)
    begin : beat_check
        beat_t want;
        if (rst_n && push && full)
            stall_cycles++;
        if (rst_n && pop && !empty)
        begin
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                $display("%0t: beat with none expected: out_byte %0h opcode %0h kind %0d last %0b",
                         $time, out_byte, frame_opcode, kind, last);
            end
            else
            begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (out_byte !== want.data)
                    report("out_byte", want.data, out_byte);
                if (frame_opcode !== want.opcode)
                    report("frame_opcode", {4'h0, want.opcode}, {4'h0, frame_opcode});
                if (kind !== want.kind)
                    report("kind", {6'd0, want.kind}, {6'd0, kind});
                if (last !== want.last)
                    report("last", {7'd0, want.last}, {7'd0, last});
            end
        end
    end

    // Result side: random pop gaps, bursts without gaps, and a long hold on request.
    initial
    begin : beat_sink
        int gap;
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 47) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 11);
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    // Offer one byte after a random gap; on acceptance queue what it should produce.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input bit t_has = 1'b0, input beat_t t_res = NO_BEAT);
        int    gap;
        bit    has;
        beat_t r;
        if ($urandom_range(0, 47) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            push    <= 1'b0;
            rx_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full) @(posedge clk);
        has = deframe_byte(b, r);
        if (typed)
        begin
            has = t_has;
            r   = t_res;
        end
        if (has)
            expected_beats = {expected_beats, r};
        bytes_in++;
    endtask

    task automatic drain_beats();
        push <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_payload(input logic [LEN_W-1:0] value);
        drain_beats();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pr_max = value;
    endtask

    // One final, masked frame with random opcode, reserved bits, key and payload.
    task automatic send_frame(input logic [63:0] len);
        int enc;
        int i;
        if (len < 64'd126)
            enc = $urandom_range(0, 3) % 3;
        else if (len < 64'd65536)
            enc = $urandom_range(1, 2);
        else
            enc = 2;
        send_byte({1'b1, 3'($urandom), 4'($urandom)});
        case (enc)
            0: send_byte({1'b1, len[6:0]});
            1:
            begin
                send_byte({1'b1, LEN7_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({1'b1, LEN7_EXT64});
                for (i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
        endcase
        repeat (4) send_byte(8'($urandom));
        for (i = 0; i < int'(len); i++)
            send_byte(8'($urandom));
        frames_sent++;
    endtask

    task automatic run_setting(input logic [LEN_W-1:0] cap, input int budget);
        int          start;
        int          pick;
        int          lim;
        logic [63:0] len;
        set_max_payload(cap);
        start = bytes_in;
        lim   = (cap < 48) ? int'(cap) : 48;
        while (bytes_in - start < budget)
        begin
            pick = $urandom_range(0, 9);
            if (cap == 0 || pick == 0)
                len = 64'd0;
            else if (pick == 1 && cap <= 200)
                len = {40'd0, cap};
            else
                len = 64'($urandom_range(1, lim));
            send_frame(len);
        end
    endtask

    initial
    begin : stimulus
        int          i;
        logic [63:0] too_long;
        beat_t       rej;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            send_byte(directed_rows[i].b, directed_rows[i].typed,
                      directed_rows[i].has, directed_rows[i].res);

        run_setting(MAX_PAYLOAD_RESET, 230);
        run_setting('0, 50);
        run_setting('1, 180);
        // Hold the sink off so the result queue fills and push stalls.
        hold_request = 1'b1;
        send_frame(64'd300);
        run_setting(24'($urandom_range(1, 40)), 250);
        run_setting(24'd125, 220);
        run_setting(24'd126, 220);

        // End on one rejection; every byte after it must be dropped.
        drain_beats();
        rej = '{8'h00, OPC_REJECT, KIND_REJECT, 1'b1};
        reject_case = $urandom_range(0, 3);
        case (reject_case)
            0:
            begin
                send_byte({1'b1, 3'($urandom), 4'($urandom)});
                send_byte({1'b0, 7'($urandom)}, 1'b1, 1'b1, rej);
            end
            1:
            begin
                send_byte({1'b0, 3'($urandom), 4'($urandom)});
                send_byte(8'($urandom), 1'b1, 1'b1, rej);
            end
            2:
            begin
                too_long = {40'd0, pr_max} + 64'd1;
                send_byte({1'b1, 3'($urandom), 4'($urandom)});
                send_byte({1'b1, LEN7_EXT16});
                send_byte(too_long[15:8]);
                send_byte(too_long[7:0], 1'b1, 1'b1, rej);
            end
            default:
            begin
                send_byte({1'b1, 3'($urandom), 4'($urandom)});
                send_byte({1'b1, LEN7_EXT64});
                send_byte(8'h80 | 8'($urandom));
                repeat (6) send_byte(8'($urandom));
                send_byte(8'($urandom), 1'b1, 1'b1, rej);
            end
        endcase
        repeat (20) send_byte(8'($urandom));
        drain_beats();

        $display("Covered %0d stream bytes in %0d good frames plus rejection case %0d,",
                 bytes_in, frames_sent, reject_case);
        $display("%0d result beats checked, %0d cycles with push stalled by full.",
                 beats_checked, stall_cycles);
        if (mismatches == 0)
            $display("websocket_frame_deframer_top regression: pass");
        else
            $display("websocket_frame_deframer_top regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("%0t: timeout with %0d beats still expected", $time, expected_beats.size());
        $display("websocket_frame_deframer_top regression: fail");
        $finish;
    end

endmodule

### websocket_frame_deframer_top.f
rtl/core/wsd_pkg.sv
rtl/core/wsd_front.sv
rtl/core/wsd_fifo.sv
rtl/core/wsd_back.sv
rtl/core/websocket_frame_deframer_top.sv
dv/testbench.sv
